/* rtl/c8_pkg.sv */
// Shared types, command codes and font table for the eight-bit VM core.
`timescale 1ns / 1ps
`default_nettype none
package c8_pkg;

  // Memory geometry and reset constants.
  localparam int MemBytes = 4096;
  localparam int AddrW = 12;
  localparam int FontBytes = 80;
  localparam logic [AddrW-1:0] ProgStartReset = 12'd512;

  // Input command codes.
  localparam logic [2:0] CMD_EXEC = 3'd0;
  localparam logic [2:0] CMD_TICK = 3'd1;
  localparam logic [2:0] CMD_LOAD = 3'd2;
  localparam logic [2:0] CMD_KEYS = 3'd3;
  localparam logic [2:0] CMD_ROW  = 3'd4;

  // Instruction codes decoded by the controller and the datapath.
  localparam logic [15:0] OP_CLS     = 16'h00E0;
  localparam logic [15:0] OP_RET     = 16'h00EE;
  localparam logic [3:0]  OPH_DRAW   = 4'hD;
  localparam logic [3:0]  OPH_MISC   = 4'hF;
  localparam logic [7:0]  KK_SKP     = 8'h9E;
  localparam logic [7:0]  KK_SKNP    = 8'hA1;
  localparam logic [7:0]  KK_GET_DT  = 8'h07;
  localparam logic [7:0]  KK_SET_DT  = 8'h15;
  localparam logic [7:0]  KK_SET_ST  = 8'h18;
  localparam logic [7:0]  KK_ADD_I   = 8'h1E;
  localparam logic [7:0]  KK_GLYPH   = 8'h29;
  localparam logic [7:0]  KK_BCD     = 8'h33;
  localparam logic [7:0]  KK_SAVE    = 8'h55;
  localparam logic [7:0]  KK_RESTORE = 8'h65;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    DC_NONE,
    DC_CLR,
    DC_FETCH0,
    DC_FETCH1,
    DC_FETCH2,
    DC_EXEC,
    DC_RD_I,
    DC_DRAW_ROW,
    DC_DRAW_END,
    DC_LOAD_V,
    DC_STORE_V,
    DC_BCD,
    DC_RESULT
  } c8_op_t;

  typedef struct packed {
    c8_op_t           op;
    logic [AddrW-1:0] cnt;
  } c8_cmd_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] opcode;
    logic        fault;
  } c8_stat_t;

  // Hex digit glyphs, five bytes each.
  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] b;
    case (a)
      7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd25, 7'd27,
      7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45, 7'd47,
      7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75, 7'd77:
        b = 8'hF0;
      7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
      7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68:
        b = 8'h90;
      7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
      7'd6: b = 8'h60;
      7'd9: b = 8'h70;
      7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
      7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
      7'd79:
        b = 8'h80;
      7'd22: b = 8'hF0;
      7'd38, 7'd39: b = 8'h40;
      7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/eight_bit_vm_instruction_core.sv */
// Top level of the eight-bit VM instruction core: controller plus datapath.
// Sequence: an instruction is fetched as two memory bytes and decoded; a draw steps
// row by row, Fx33 digit by digit, Fx55 and Fx65 register by register.
// Throughput: one beat at a time; busy drops while the result strobe is high, so
// the next beat can be accepted at that edge; the single memory port sets the step.
// Reset: synchronous; a clearing pass over all 4096 bytes reloads the font and
// zeroes memory while busy is high. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module eight_bit_vm_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [11:0] in_load_address,
  input  wire logic [7:0]  in_load_byte,
  input  wire logic [15:0] in_keys_down,
  input  wire logic [7:0]  in_random_byte,
  input  wire logic [4:0]  in_row_select,
  output logic             out_valid,
  output logic [11:0]      out_program_counter,
  output logic [15:0]      out_executed_opcode,
  output logic             out_drew_sprite,
  output logic             out_fault,
  output logic             out_sound_on,
  output logic [63:0]      out_row_pixels
);

  c8_pkg::c8_cmd_t  cmd;
  c8_pkg::c8_stat_t stat;
  logic accept;

  assign accept = start & ~busy;

  c8_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .busy(busy), .cmd(cmd)
  );

  c8_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .accept(accept), .cmd(cmd), .stat(stat),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_cmd(in_cmd), .in_load_address(in_load_address), .in_load_byte(in_load_byte),
    .in_keys_down(in_keys_down), .in_random_byte(in_random_byte),
    .in_row_select(in_row_select),
    .out_valid(out_valid), .out_program_counter(out_program_counter),
    .out_executed_opcode(out_executed_opcode), .out_drew_sprite(out_drew_sprite),
    .out_fault(out_fault), .out_sound_on(out_sound_on),
    .out_row_pixels(out_row_pixels)
  );

endmodule
`default_nettype wire

/* rtl/c8_ctrl.sv */
// Controller state machine that sequences each command through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module c8_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire c8_pkg::c8_stat_t stat,
  output logic                busy,
  output c8_pkg::c8_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_F0, S_F1, S_F2, S_DEC, S_EXEC,
    S_DRD, S_DWR, S_DEND, S_BCD, S_STV, S_LRD, S_LWR, S_RES
  } state_t;

  state_t state_r, state_nxt;
  logic [c8_pkg::AddrW-1:0] cnt_r, cnt_nxt;
  logic busy_r;
  logic [3:0] hi, x, n;
  logic [7:0] kk;

  assign hi = stat.opcode[15:12];
  assign x  = stat.opcode[11:8];
  assign n  = stat.opcode[3:0];
  assign kk = stat.opcode[7:0];
  assign busy = busy_r;

  // Next state and micro-operation for the current state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd.op = c8_pkg::DC_NONE;
    cmd.cnt = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = c8_pkg::DC_CLR;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == c8_pkg::AddrW'(c8_pkg::MemBytes - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) state_nxt = S_DISP;
      S_DISP: begin
        if (stat.cmd == c8_pkg::CMD_EXEC && !stat.fault) state_nxt = S_F0;
        else state_nxt = S_EXEC;
      end
      S_F0: begin
        cmd.op = c8_pkg::DC_FETCH0;
        state_nxt = S_F1;
      end
      S_F1: begin
        cmd.op = c8_pkg::DC_FETCH1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.op = c8_pkg::DC_FETCH2;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cnt_nxt = '0;
        if (hi == c8_pkg::OPH_DRAW) state_nxt = (n == 4'd0) ? S_DEND : S_DRD;
        else if (hi == c8_pkg::OPH_MISC && kk == c8_pkg::KK_BCD) state_nxt = S_BCD;
        else if (hi == c8_pkg::OPH_MISC && kk == c8_pkg::KK_SAVE) state_nxt = S_STV;
        else if (hi == c8_pkg::OPH_MISC && kk == c8_pkg::KK_RESTORE) state_nxt = S_LRD;
        else state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.op = c8_pkg::DC_EXEC;
        state_nxt = S_RES;
      end
      S_DRD: begin
        cmd.op = c8_pkg::DC_RD_I;
        state_nxt = S_DWR;
      end
      S_DWR: begin
        cmd.op = c8_pkg::DC_DRAW_ROW;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r[3:0] == n - 4'd1) ? S_DEND : S_DRD;
      end
      S_DEND: begin
        cmd.op = c8_pkg::DC_DRAW_END;
        state_nxt = S_RES;
      end
      S_BCD: begin
        cmd.op = c8_pkg::DC_BCD;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd2) state_nxt = S_RES;
      end
      S_STV: begin
        cmd.op = c8_pkg::DC_STORE_V;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == x) state_nxt = S_RES;
      end
      S_LRD: begin
        cmd.op = c8_pkg::DC_RD_I;
        state_nxt = S_LWR;
      end
      S_LWR: begin
        cmd.op = c8_pkg::DC_LOAD_V;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r[3:0] == x) ? S_RES : S_LRD;
      end
      S_RES: begin
        cmd.op = c8_pkg::DC_RESULT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, step counter and registered busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      busy_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      busy_r <= (state_nxt != S_IDLE);
    end
  end

endmodule
`default_nettype wire

/* rtl/c8_dp.sv */
// Datapath: memory, registers, stack, timers, display and result registers.
`timescale 1ns / 1ps
`default_nettype none
module c8_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire c8_pkg::c8_cmd_t cmd,
  output c8_pkg::c8_stat_t     stat,
  input  wire logic            cfg_wr_en,
  input  wire logic [11:0]     cfg_wr_data,
  input  wire logic [2:0]      in_cmd,
  input  wire logic [11:0]     in_load_address,
  input  wire logic [7:0]      in_load_byte,
  input  wire logic [15:0]     in_keys_down,
  input  wire logic [7:0]      in_random_byte,
  input  wire logic [4:0]      in_row_select,
  output logic                 out_valid,
  output logic [11:0]          out_program_counter,
  output logic [15:0]          out_executed_opcode,
  output logic                 out_drew_sprite,
  output logic                 out_fault,
  output logic                 out_sound_on,
  output logic [63:0]          out_row_pixels
);

  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SDW = $clog2(STACK_DEPTH + 1);

  // Main memory with registered read.
  logic [7:0] mem [c8_pkg::MemBytes];
  logic [7:0] rdata_r;
  logic [11:0] mem_addr;
  logic mem_we;
  logic [7:0] mem_wdata;

  logic [7:0]  v_r [16];
  logic [63:0] disp_r [32];
  logic [11:0] stack_r [STACK_DEPTH];
  logic [SDW-1:0] depth_r, depth_m1;
  logic [11:0] pc_r, prog_start_r;
  logic [15:0] idx_r, op_r, keys_r;
  logic [7:0]  dly_r, snd_r;
  logic        fault_r, hit_r, drew_r;
  logic [63:0] row_r;
  logic [2:0]  cmd_r;
  logic [11:0] load_addr_r;
  logic [7:0]  load_byte_r, rnd_r;
  logic [4:0]  row_sel_r;
  logic [15:0] keys_in_r;

  logic [3:0]  hi, x, y, cnt4;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn, i_addr;
  logic [8:0]  sum9;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_p;
  logic [3:0]  tens, ones;
  logic [4:0]  disp_idx;
  logic [63:0] disp_row, sprite, mask;
  logic [127:0] dbl;
  logic        valid_r;

  assign hi = op_r[15:12];
  assign x = op_r[11:8];
  assign y = op_r[7:4];
  assign kk = op_r[7:0];
  assign nnn = op_r[11:0];
  assign vx = v_r[x];
  assign vy = v_r[y];
  assign cnt4 = cmd.cnt[3:0];
  assign i_addr = idx_r[11:0] + {8'd0, cnt4};
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign depth_m1 = depth_r - 1'b1;

  assign stat.cmd = cmd_r;
  assign stat.opcode = op_r;
  assign stat.fault = fault_r;

  // Decimal digits of Vx by constant compares and a reciprocal multiply.
  always_comb begin
    if (vx >= 8'd200) hund = 2'd2;
    else if (vx >= 8'd100) hund = 2'd1;
    else hund = 2'd0;
    rem = 7'(vx - 8'(hund) * 8'd100);
    tens_p = 15'(rem) * 15'd205;
    tens = 4'(tens_p >> 11);
    ones = 4'(rem - 7'(tens) * 7'd10);
  end

  // Memory port address and write selection.
  always_comb begin
    mem_addr = pc_r;
    mem_we = 1'b0;
    mem_wdata = 8'd0;
    case (cmd.op)
      c8_pkg::DC_CLR: begin
        mem_addr = cmd.cnt;
        mem_we = 1'b1;
        mem_wdata = (cmd.cnt < 12'(c8_pkg::FontBytes)) ?
                    c8_pkg::font_byte(cmd.cnt[6:0]) : 8'd0;
      end
      c8_pkg::DC_FETCH1: mem_addr = pc_r + 12'd1;
      c8_pkg::DC_RD_I: mem_addr = i_addr;
      c8_pkg::DC_STORE_V: begin
        mem_addr = i_addr;
        mem_we = 1'b1;
        mem_wdata = v_r[cnt4];
      end
      c8_pkg::DC_BCD: begin
        mem_addr = i_addr;
        mem_we = 1'b1;
        case (cmd.cnt[1:0])
          2'd0: mem_wdata = {6'd0, hund};
          2'd1: mem_wdata = {4'd0, tens};
          default: mem_wdata = {4'd0, ones};
        endcase
      end
      c8_pkg::DC_EXEC: begin
        if (cmd_r == c8_pkg::CMD_LOAD) begin
          mem_addr = load_addr_r;
          mem_we = 1'b1;
          mem_wdata = load_byte_r;
        end
      end
      default: mem_addr = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  // Display row select and sprite mask rotated to column Vx.
  always_comb begin
    disp_idx = (cmd.op == c8_pkg::DC_DRAW_ROW) ? 5'(vy[4:0] + cmd.cnt[4:0]) : row_sel_r;
    disp_row = disp_r[disp_idx];
    sprite = {rdata_r, 56'd0};
    dbl = {sprite, sprite} >> vx[5:0];
    mask = dbl[63:0];
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      load_addr_r <= in_load_address;
      load_byte_r <= in_load_byte;
      keys_in_r <= in_keys_down;
      rnd_r <= in_random_byte;
      row_sel_r <= in_row_select;
    end
  end

  // Architectural state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) v_r[i] <= 8'd0;
      for (int i = 0; i < 32; i++) disp_r[i] <= 64'd0;
      depth_r <= '0;
      pc_r <= c8_pkg::ProgStartReset;
      prog_start_r <= c8_pkg::ProgStartReset;
      idx_r <= 16'd0;
      dly_r <= 8'd0;
      snd_r <= 8'd0;
      keys_r <= 16'd0;
      fault_r <= 1'b0;
      op_r <= 16'd0;
      hit_r <= 1'b0;
      drew_r <= 1'b0;
      row_r <= 64'd0;
    end else begin
      if (cfg_wr_en) prog_start_r <= cfg_wr_data;
      if (accept) begin
        op_r <= 16'd0;
        hit_r <= 1'b0;
        drew_r <= 1'b0;
        row_r <= 64'd0;
      end
      case (cmd.op)
        c8_pkg::DC_FETCH1: op_r[15:8] <= rdata_r;
        c8_pkg::DC_FETCH2: begin
          op_r[7:0] <= rdata_r;
          pc_r <= pc_r + 12'd2;
        end
        c8_pkg::DC_DRAW_ROW: begin
          disp_r[disp_idx] <= disp_row ^ mask;
          hit_r <= hit_r | (|(disp_row & mask));
        end
        c8_pkg::DC_DRAW_END: begin
          v_r[15] <= {7'd0, hit_r};
          drew_r <= 1'b1;
        end
        c8_pkg::DC_LOAD_V: v_r[cnt4] <= rdata_r;
        c8_pkg::DC_EXEC: begin
          case (cmd_r)
            c8_pkg::CMD_EXEC: begin
              if (!fault_r) begin
                case (hi)
                  4'h0: begin
                    if (op_r == c8_pkg::OP_CLS) begin
                      for (int i = 0; i < 32; i++) disp_r[i] <= 64'd0;
                    end else if (op_r == c8_pkg::OP_RET) begin
                      if (depth_r == '0) fault_r <= 1'b1;
                      else begin
                        depth_r <= depth_m1;
                        pc_r <= stack_r[depth_m1[SIW-1:0]];
                      end
                    end else fault_r <= 1'b1;
                  end
                  4'h1: pc_r <= nnn;
                  4'h2: begin
                    if (depth_r >= SDW'(STACK_DEPTH)) fault_r <= 1'b1;
                    else begin
                      stack_r[depth_r[SIW-1:0]] <= pc_r;
                      depth_r <= depth_r + 1'b1;
                      pc_r <= nnn;
                    end
                  end
                  4'h3: if (vx == kk) pc_r <= pc_r + 12'd2;
                  4'h4: if (vx != kk) pc_r <= pc_r + 12'd2;
                  4'h5: if (vx == vy) pc_r <= pc_r + 12'd2;
                  4'h6: v_r[x] <= kk;
                  4'h7: v_r[x] <= vx + kk;
                  4'h8: begin
                    case (op_r[3:0])
                      4'h0: v_r[x] <= vy;
                      4'h1: v_r[x] <= vx | vy;
                      4'h2: v_r[x] <= vx & vy;
                      4'h3: v_r[x] <= vx ^ vy;
                      4'h4: begin
                        v_r[15] <= {7'd0, sum9[8]};
                        v_r[x] <= sum9[7:0];
                      end
                      4'h5: begin
                        v_r[15] <= {7'd0, vx > vy};
                        v_r[x] <= vx - vy;
                      end
                      4'h6: begin
                        v_r[15] <= {7'd0, vx[0]};
                        v_r[x] <= {1'b0, vx[7:1]};
                      end
                      4'h7: begin
                        v_r[15] <= {7'd0, vy > vx};
                        v_r[x] <= vy - vx;
                      end
                      4'hE: begin
                        v_r[15] <= {7'd0, vx[7]};
                        v_r[x] <= {vx[6:0], 1'b0};
                      end
                      default: fault_r <= 1'b1;
                    endcase
                  end
                  4'h9: if (vx != vy) pc_r <= pc_r + 12'd2;
                  4'hA: idx_r <= {4'd0, nnn};
                  4'hB: pc_r <= nnn + {4'd0, v_r[0]};
                  4'hC: v_r[x] <= rnd_r & kk;
                  4'hE: begin
                    if (kk == c8_pkg::KK_SKP) begin
                      if (keys_r[vx[3:0]]) pc_r <= pc_r + 12'd2;
                    end else if (kk == c8_pkg::KK_SKNP) begin
                      if (!keys_r[vx[3:0]]) pc_r <= pc_r + 12'd2;
                    end else fault_r <= 1'b1;
                  end
                  c8_pkg::OPH_MISC: begin
                    case (kk)
                      c8_pkg::KK_GET_DT: v_r[x] <= dly_r;
                      c8_pkg::KK_SET_DT: dly_r <= vx;
                      c8_pkg::KK_SET_ST: snd_r <= vx;
                      c8_pkg::KK_ADD_I: idx_r <= idx_r + {8'd0, vx};
                      c8_pkg::KK_GLYPH:
                        idx_r <= {10'd0, vx[3:0], 2'd0} + {12'd0, vx[3:0]};
                      default: fault_r <= 1'b1;
                    endcase
                  end
                  default: ;
                endcase
              end
            end
            c8_pkg::CMD_TICK: begin
              if (dly_r != 8'd0) dly_r <= dly_r - 8'd1;
              if (snd_r != 8'd0) snd_r <= snd_r - 8'd1;
            end
            c8_pkg::CMD_LOAD: pc_r <= prog_start_r;
            c8_pkg::CMD_KEYS: keys_r <= keys_in_r;
            c8_pkg::CMD_ROW: row_r <= disp_row;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result beat registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      out_program_counter <= 12'd0;
      out_executed_opcode <= 16'd0;
      out_drew_sprite <= 1'b0;
      out_fault <= 1'b0;
      out_sound_on <= 1'b0;
      out_row_pixels <= 64'd0;
    end else begin
      valid_r <= (cmd.op == c8_pkg::DC_RESULT);
      if (cmd.op == c8_pkg::DC_RESULT) begin
        out_program_counter <= pc_r;
        out_executed_opcode <= op_r;
        out_drew_sprite <= drew_r;
        out_fault <= fault_r;
        out_sound_on <= (snd_r != 8'd0);
        out_row_pixels <= row_r;
      end
    end
  end

  assign out_valid = valid_r;

endmodule
`default_nettype wire

/* rtl/c8_checker.sv */
// Port-level checker for the eight-bit VM core and its bind.
`timescale 1ns / 1ps
`default_nettype none
module c8_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_fault,
  input wire logic [15:0] out_executed_opcode
);

  // Reset starts the memory clearing pass.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // An accepted beat makes the core busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // Each result comes from a busy period and never repeats in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two cycles in a row");

  // The fault flag is sticky.
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(out_fault))
    else $error("fault flag cleared without reset");

  // A faulted core reports no executed instruction on later results.
  a_fault_noop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fault && !out_valid) ##1 out_valid |-> out_executed_opcode == 16'd0)
    else $error("instruction executed after fault");

endmodule

bind eight_bit_vm_instruction_core c8_checker u_c8_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_fault(out_fault), .out_executed_opcode(out_executed_opcode)
);
`default_nettype wire
